// ----- sv/bmea_pkg.sv -----
// shared constants and register codes of the binary map erosion area unit
package bmea_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int DIM_W   = 7;   // map_rows, map_cols
  localparam int PASS_W  = 8;   // erosion_passes
  localparam int COUNT_W = 13;  // initial_land, final_land
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [DIM_W-1:0]  ROWS_RESET   = 7'd64;
  localparam logic [DIM_W-1:0]  COLS_RESET   = 7'd64;
  localparam logic [PASS_W-1:0] PASSES_RESET = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_ROWS       = 2'd0,
    REG_MAP_COLS       = 2'd1,
    REG_EROSION_PASSES = 2'd2
  } cfg_reg_t;

endpackage

// ----- sv/bmea_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module bmea_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/binary_map_erosion_area_unit.sv -----
// binary map erosion area unit: loads a map, erodes it and reports land counts
//
// Cells enter on s_axis one item per cycle in row-major order, tdata[0] set for
// water, tlast on the final cell. Map size and pass count come from the cfg
// channel (index 0 rows, 1 cols, 2 passes), written by the user only while
// the block idles, which the block does not enforce. After the last cell it
// stops taking items and works on the map: its count scan makes one ram read
// per cycle; each pass makes five neighbour reads and one write per cell
// through the single read port of the map ram; passes stop early once a
// pass changes no cell.
// One result item then goes to m_axis: tdata[12:0] initial land count,
// tdata[25:13] final land count. The output register holds the item until
// m_axis_tready; the next map may already load meanwhile, and the block
// only waits in its output state if the previous result is still pending.
// The eroded map stays in the ram, so a short next map keeps those cells.
// Reset sets rows and cols to 64, passes to 0, and empties the output; ram
// contents are not cleared.
module binary_map_erosion_area_unit #(
  parameter int MAX_ROWS = bmea_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = bmea_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // cfg write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmea_pkg::CFG_DATA_W-1:0] cfg_data,
  // cell items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bmea_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [0] cell_is_water
  input  logic                           s_axis_tlast,   // last_cell
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bmea_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [12:0] initial_land,
                                                          // [25:13] final_land
);

  import bmea_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int RSW   = $clog2(MAX_ROWS + 1);
  localparam int CSW   = $clog2(MAX_COLS + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_COUNT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PASS  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // cell phases: read center, left, right, up, down, then write
  typedef enum logic [2:0] {
    PH_C = 3'd0,
    PH_L = 3'd1,
    PH_R = 3'd2,
    PH_U = 3'd3,
    PH_D = 3'd4,
    PH_W = 3'd5
  } phase_t;

  state_t state;
  phase_t phase;

  logic [DIM_W-1:0]  map_rows;
  logic [DIM_W-1:0]  map_cols;
  logic [PASS_W-1:0] erosion_passes;

  logic [PW-1:0]  load_pos;
  logic           cur;          // bank holding the current map
  logic [AW-1:0]  k;
  logic [RSW-1:0] r;
  logic [CSW-1:0] c;
  logic [PASS_W-1:0] pass_idx;
  logic [3:0]     nb;           // center, left, right, up land bits
  logic           rd_inside_q;
  logic           cnt_v;
  logic           changed;
  logic [PW-1:0]  cnt_before;
  logic [PW-1:0]  cnt_after;
  logic [PW-1:0]  final_cnt;
  logic [COUNT_W-1:0] out_init;
  logic [COUNT_W-1:0] out_final;
  logic           m_valid;

  // clamped map size
  logic [31:0]    rows_w, cols_w;
  logic [RSW-1:0] rows_sz;
  logic [CSW-1:0] cols_sz;
  logic [PW-1:0]  cells;

  assign rows_w  = 32'(map_rows);
  assign cols_w  = 32'(map_cols);
  assign rows_sz = (rows_w == 32'd0) ? RSW'(1) :
                   (rows_w > 32'(MAX_ROWS)) ? RSW'(MAX_ROWS) : RSW'(rows_w);
  assign cols_sz = (cols_w == 32'd0) ? CSW'(1) :
                   (cols_w > 32'(MAX_COLS)) ? CSW'(MAX_COLS) : CSW'(cols_w);
  assign cells   = PW'(rows_sz) * PW'(cols_sz);

  // scan position
  logic [CSW-1:0] c_inc;
  logic [RSW-1:0] r_inc;
  logic           c_last, r_last, c_first, r_first;

  assign c_inc   = c + CSW'(1);
  assign r_inc   = r + RSW'(1);
  assign c_last  = (c_inc == cols_sz);
  assign r_last  = (r_inc == rows_sz);
  assign c_first = (c == '0);
  assign r_first = (r == '0);

  // handshakes
  logic s_fire, cfg_fire;
  assign s_axis_tready = (state == S_LOAD);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid && cfg_ready;

  // map ram banks
  logic          load_we, pass_we;
  logic          we0, we1;
  logic [AW-1:0] waddr, raddr;
  logic          wdata;
  logic          rd0, rd1, rdata;
  logic          rd_inside;
  logic          rd_land;
  logic          new_land;

  assign rdata    = cur ? rd1 : rd0;
  assign rd_land  = rd_inside_q & ~rdata;
  assign new_land = (&nb) & rd_land;

  assign load_we = s_fire && (load_pos < cells);
  assign pass_we = (state == S_PASS) && (phase == PH_W);
  assign we0     = (load_we && !cur) || (pass_we && cur);
  assign we1     = (load_we && cur) || (pass_we && !cur);
  assign waddr   = (state == S_LOAD) ? AW'(load_pos) : k;
  assign wdata   = (state == S_LOAD) ? s_axis_tdata[0] : ~new_land;

  always_comb begin
    raddr     = k;
    rd_inside = 1'b1;
    if (state == S_PASS) begin
      unique case (phase)
        PH_C: begin
          raddr     = k;
          rd_inside = 1'b1;
        end
        PH_L: begin
          raddr     = k - AW'(1);
          rd_inside = !c_first;
        end
        PH_R: begin
          raddr     = k + AW'(1);
          rd_inside = !c_last;
        end
        PH_U: begin
          raddr     = k - AW'(cols_sz);
          rd_inside = !r_first;
        end
        PH_D: begin
          raddr     = k + AW'(cols_sz);
          rd_inside = !r_last;
        end
        PH_W: begin
          raddr     = k;
          rd_inside = 1'b0;
        end
        default: begin
          raddr     = k;
          rd_inside = 1'b0;
        end
      endcase
    end
  end

  bmea_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_bank0 (
    .clk  (clk),
    .we   (we0),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd0)
  );

  bmea_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_bank1 (
    .clk  (clk),
    .we   (we1),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd1)
  );

  logic [PW-1:0] cnt_sum;
  logic          changed_now;
  assign cnt_sum     = cnt_before + PW'(!rdata);
  assign changed_now = changed | (nb[3] & ~new_land);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      phase          <= PH_C;
      map_rows       <= ROWS_RESET;
      map_cols       <= COLS_RESET;
      erosion_passes <= PASSES_RESET;
      load_pos       <= '0;
      cur            <= 1'b0;
      cnt_v          <= 1'b0;
      rd_inside_q    <= 1'b0;
      m_valid        <= 1'b0;
      cnt_before     <= '0;
    end else begin
      rd_inside_q <= rd_inside;
      cnt_v       <= (state == S_COUNT);

      if (cfg_fire) begin
        case (cfg_index)
          REG_MAP_ROWS:       map_rows       <= cfg_data[DIM_W-1:0];
          REG_MAP_COLS:       map_cols       <= cfg_data[DIM_W-1:0];
          REG_EROSION_PASSES: erosion_passes <= cfg_data[PASS_W-1:0];
          default: ;
        endcase
      end

      if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (s_fire) begin
            if (load_pos != {PW{1'b1}}) begin
              load_pos <= load_pos + PW'(1);
            end
            if (s_axis_tlast) begin
              state      <= S_COUNT;
              k          <= '0;
              cnt_before <= '0;
            end
          end
        end

        S_COUNT: begin
          if (cnt_v) begin
            cnt_before <= cnt_sum;
          end
          if (PW'(k) == cells - PW'(1)) begin
            state <= S_DRAIN;
          end else begin
            k <= k + AW'(1);
          end
        end

        S_DRAIN: begin
          cnt_before <= cnt_sum;
          final_cnt  <= cnt_sum;
          if (erosion_passes == '0) begin
            state <= S_OUT;
          end else begin
            state     <= S_PASS;
            phase     <= PH_C;
            k         <= '0;
            r         <= '0;
            c         <= '0;
            pass_idx  <= '0;
            cnt_after <= '0;
            changed   <= 1'b0;
          end
        end

        S_PASS: begin
          if (phase != PH_W) begin
            nb <= {nb[2:0], rd_land};
          end
          unique case (phase)
            PH_C: phase <= PH_L;
            PH_L: phase <= PH_R;
            PH_R: phase <= PH_U;
            PH_U: phase <= PH_D;
            PH_D: phase <= PH_W;
            PH_W: begin
              phase <= PH_C;
              if (c_last && r_last) begin
                // pass done: the scratch bank becomes the map
                cur      <= ~cur;
                pass_idx <= pass_idx + PASS_W'(1);
                if (!changed_now || (pass_idx + PASS_W'(1) == erosion_passes)) begin
                  final_cnt <= cnt_after + PW'(new_land);
                  state     <= S_OUT;
                end else begin
                  k         <= '0;
                  r         <= '0;
                  c         <= '0;
                  cnt_after <= '0;
                  changed   <= 1'b0;
                end
              end else begin
                cnt_after <= cnt_after + PW'(new_land);
                changed   <= changed_now;
                k         <= k + AW'(1);
                if (c_last) begin
                  c <= '0;
                  r <= r_inc;
                end else begin
                  c <= c_inc;
                end
              end
            end
            default: phase <= PH_C;
          endcase
        end

        S_OUT: begin
          if (!m_valid || m_axis_tready) begin
            m_valid   <= 1'b1;
            out_init  <= COUNT_W'(cnt_before);
            out_final <= COUNT_W'(final_cnt);
            load_pos  <= '0;
            state     <= S_LOAD;
          end
        end

        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2 * COUNT_W){1'b0}}, out_final, out_init};

endmodule

// ----- tb/erosion_area_checker.sv -----
// checker of the erosion area unit: predicts land counts of each map and compares result items
module erosion_area_checker
  import bmea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] cell_is_water
  input  logic                  s_axis_tlast,   // last_cell
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [12:0] initial_land, [25:13] final_land
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int POS_LIMIT   = 2**COUNT_W - 1;

  typedef struct packed {
    logic [COUNT_W-1:0] initial_land;
    logic [COUNT_W-1:0] final_land;
  } land_counts_t;

  land_counts_t       expected_counts[$];
  bit                 map_now [STORE_CELLS];   // 1 water, 0 land
  bit                 map_next [STORE_CELLS];
  logic [DIM_W-1:0]   rows_cfg;
  logic [DIM_W-1:0]   cols_cfg;
  logic [PASS_W-1:0]  passes_cfg;
  int                 load_pos;
  int                 errors;

  function automatic int dim_in_use(logic [DIM_W-1:0] raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // cells outside the map count as water
  function automatic bit is_land(int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b0;
    return !map_now[r * nc + c];
  endfunction

  function automatic int count_land(int n_cells);
    int n;
    n = 0;
    for (int i = 0; i < n_cells; i++)
      if (!map_now[i]) n++;
    return n;
  endfunction

  // one erosion pass over the map, returns whether any cell turned to water
  function automatic bit erode_step(int nr, int nc);
    bit changed;
    bit v;
    int k;
    changed = 1'b0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        k = r * nc + c;
        v = map_now[k];
        if (!v && !(is_land(r, c - 1, nr, nc) && is_land(r + 1, c, nr, nc) &&
                    is_land(r, c + 1, nr, nc) && is_land(r - 1, c, nr, nc))) begin
          v = 1'b1;
          changed = 1'b1;
        end
        map_next[k] = v;
      end
    end
    for (int i = 0; i < nr * nc; i++)
      map_now[i] = map_next[i];
    return changed;
  endfunction

  always @(posedge clk) begin
    land_counts_t want;
    land_counts_t got;
    int nr;
    int nc;
    bit still_going;
    if (rst) begin
      rows_cfg   = ROWS_RESET;
      cols_cfg   = COLS_RESET;
      passes_cfg = PASSES_RESET;
      load_pos   = 0;
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_ROWS:       rows_cfg   = cfg_data[DIM_W-1:0];
          REG_MAP_COLS:       cols_cfg   = cfg_data[DIM_W-1:0];
          REG_EROSION_PASSES: passes_cfg = cfg_data[PASS_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        nr = dim_in_use(rows_cfg, MAX_ROWS_DEF);
        nc = dim_in_use(cols_cfg, MAX_COLS_DEF);
        // cells past the end of the map are dropped, position saturates
        if (load_pos < nr * nc) map_now[load_pos] = s_axis_tdata[0];
        if (load_pos < POS_LIMIT) load_pos++;
        if (s_axis_tlast) begin
          want.initial_land = COUNT_W'(count_land(nr * nc));
          still_going = 1'b1;
          for (int p = 0; p < passes_cfg && still_going; p++)
            still_going = erode_step(nr, nc);
          want.final_land = COUNT_W'(count_land(nr * nc));
          expected_counts.push_back(want);
          load_pos = 0;
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.initial_land = m_axis_tdata[COUNT_W-1:0];
        got.final_land   = m_axis_tdata[2*COUNT_W-1:COUNT_W];
        if (expected_counts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result item: initial %0d final %0d",
                     got.initial_land, got.final_land);
        end else begin
          want = expected_counts.pop_front();
          if (got.initial_land !== want.initial_land || got.final_land !== want.final_land) begin
            errors++;
            if (errors <= 10)
              $display("land count mismatch: expected initial %0d final %0d, got initial %0d final %0d",
                       want.initial_land, want.final_land, got.initial_land, got.final_land);
          end
        end
      end
    end
    mismatches  <= errors;
    outstanding <= expected_counts.size();
  end

endmodule

// ----- tb/binary_map_erosion_area_unit_tb.sv -----
// testbench top of the erosion area unit: drives maps and config, gives the verdict
module binary_map_erosion_area_unit_tb;
  import bmea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 400000;
  localparam int SETTLE      = 16;
  localparam int TAIL_CYCLES = 5000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MAP_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [0] cell_is_water
  logic                  s_axis_tlast = 1'b0; // last_cell
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [12:0] initial_land, [25:13] final_land
  int                    failures;
  int                    pending;

  binary_map_erosion_area_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  erosion_area_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (failures),
    .outstanding   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int dim_in_use(logic [CFG_DATA_W-1:0] raw, int hi);
    int v;
    v = raw[DIM_W-1:0];
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 6);
    if (r == 7) return 0;
    if (r == 8) return $urandom_range(7, 12);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_passes();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 2);
    if (r < 7) return $urandom_range(3, 8);
    if (r == 7) return 255;
    return $urandom_range(0, 255);
  endfunction

  // stop feeding cells and wait until every expected result item is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows_raw,
                           input logic [CFG_DATA_W-1:0] cols_raw,
                           input logic [CFG_DATA_W-1:0] passes_raw,
                           input bit poke_unused);
    drain();
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_MAP_ROWS, rows_raw);
      cfg_write(REG_MAP_COLS, cols_raw);
      cfg_write(REG_EROSION_PASSES, passes_raw);
    end else begin
      cfg_write(REG_EROSION_PASSES, passes_raw);
      cfg_write(REG_MAP_COLS, cols_raw);
      cfg_write(REG_MAP_ROWS, rows_raw);
    end
    if (poke_unused) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // n_items cells, the first land_head of them land, the rest water with the given chance
  task automatic send_map(input int n_items, input int land_head, input int water_pct);
    bit steady;
    bit water;
    int gap;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      water = (i >= land_head) && ($urandom_range(0, 99) < water_pct);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= IN_DATA_W'(water);
      s_axis_tlast  <= (i == n_items - 1);
      do @(posedge clk); while (!s_axis_tready);
    end
  endtask

  // result side stalls in runs, mostly short
  initial begin : result_sink
    int r;
    int run;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 50);
      end else begin
        m_axis_tready <= 1'b0;
        if (r < 85) run = $urandom_range(1, 3);
        else if (r < 97) run = $urandom_range(4, 15);
        else run = $urandom_range(30, 200);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rows_raw;
    logic [CFG_DATA_W-1:0] cols_raw;
    int area;
    int n;
    int kind;
    int wp;
    int loaded;
    int maps_done;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full map at the reset size, so the whole store holds written cells from here on
    drain();
    cfg_write(REG_EROSION_PASSES, 8'd255);
    cfg_valid <= 1'b0;
    send_map(MAX_ROWS_DEF * MAX_COLS_DEF, 0, 50);

    // single cell maps, outside counts as water
    configure(8'd1, 8'd1, 8'd0, 1'b0);
    send_map(1, 1, 0);
    send_map(1, 0, 100);
    configure(8'd1, 8'd1, 8'd1, 1'b0);
    send_map(1, 1, 0);

    // 3x3 all land: one pass leaves the center, two leave nothing
    configure(8'd3, 8'd3, 8'd1, 1'b0);
    send_map(9, 9, 0);
    configure(8'd3, 8'd3, 8'd2, 1'b0);
    send_map(9, 9, 0);
    // short map keeps the eroded cells it does not overwrite
    configure(8'd3, 8'd3, 8'd0, 1'b0);
    send_map(2, 2, 0);

    // sizes clamped from zero and from above the maximum
    configure(8'd0, 8'd200, 8'd255, 1'b0);
    send_map(64, 64, 0);
    configure(8'd127, 8'd1, 8'd3, 1'b0);
    send_map(64, 0, 25);

    // extra cells past the map are dropped
    configure(8'd2, 8'd2, 8'd0, 1'b1);
    send_map(7, 4, 100);
    // very long map: load position must saturate, not wrap onto cell 0
    configure(8'd1, 8'd1, 8'd0, 1'b0);
    send_map(8200, 1, 100);

    // land vanishes before the pass count runs out
    configure(8'd5, 8'd4, 8'd255, 1'b0);
    send_map(20, 20, 0);

    loaded = 0;
    maps_done = 0;
    area = 1;
    while (loaded < 500 || maps_done < 40) begin
      if (maps_done == 0 || $urandom_range(0, 3) == 0) begin
        rows_raw = pick_dim();
        cols_raw = pick_dim();
        area = dim_in_use(rows_raw, MAX_ROWS_DEF) * dim_in_use(cols_raw, MAX_COLS_DEF);
        if (area > 256) begin
          cols_raw = $urandom_range(1, 4);
          area = dim_in_use(rows_raw, MAX_ROWS_DEF) * cols_raw;
        end
        configure(rows_raw, cols_raw, pick_passes(), $urandom_range(0, 9) == 0);
      end
      kind = $urandom_range(0, 99);
      n = area;
      if (kind < 10 && area > 1) n = $urandom_range(1, area - 1);
      else if (kind < 20) n = area + $urandom_range(1, 6);
      else if (kind < 24) n = 1;
      kind = $urandom_range(0, 99);
      if (kind < 10) wp = 0;
      else if (kind < 15) wp = 100;
      else begin
        case ($urandom_range(0, 3))
          0: wp = 12;
          1: wp = 25;
          2: wp = 50;
          default: wp = 75;
        endcase
      end
      send_map(n, 0, wp);
      loaded += (n < area) ? n : area;
      maps_done++;
    end

    drain();
    // a stray result item would still show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
